// ----- sv/b64enc_pkg.sv -----
`timescale 1ns / 1ps

package b64enc_pkg;

    localparam logic [6:0] CH_CR  = 7'd13;
    localparam logic [6:0] CH_LF  = 7'd10;
    localparam logic [6:0] CH_PAD = 7'd61;

    localparam logic [4:0] GROUPS_PER_LINE_RESET = 5'd19;

    // character slots of one group
    localparam logic [2:0] SLOT_CR = 3'd4;
    localparam logic [2:0] SLOT_LF = 3'd5;

    // one group of output characters, built by the front and spelled by the back
    typedef struct packed {
        logic [7:0] b0;
        logic [7:0] b1;
        logic [7:0] b2;
        logic [1:0] pad;
        logic       crlf;
        logic       msg_last;
    } job_t;

    function automatic logic [6:0] sym_char(input logic [5:0] v);
        logic [6:0] c;
        if (v < 6'd26)
        begin
            c = 7'd65 + {1'b0, v};
        end
        else if (v < 6'd52)
        begin
            c = 7'd71 + {1'b0, v};
        end
        else if (v < 6'd62)
        begin
            c = {1'b0, v} - 7'd4;
        end
        else if (v == 6'd62)
        begin
            c = 7'd43;
        end
        else
        begin
            c = 7'd47;
        end
        return c;
    endfunction

endpackage

// ----- sv/b64enc_front.sv -----
`timescale 1ns / 1ps

module b64enc_front (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  logic [7:0]           data_byte,
    input  logic                 byte_present,
    input  logic                 end_of_message,
    input  logic                 cfg_wr_en,
    input  logic [4:0]           cfg_wr_data,
    input  logic                 q_full,
    output logic                 q_push,
    output b64enc_pkg::job_t     q_job
);

    logic [4:0] gpl_reg;
    logic [7:0] held0_reg, held0_next;
    logic [7:0] held1_reg, held1_next;
    logic [1:0] cnt_reg, cnt_next;
    logic [4:0] gol_reg, gol_next;

    logic       accept;
    logic       full_group;
    logic       tail;
    logic [4:0] gol_inc;
    logic [1:0] cnt_byte;

    assign in_stall = q_full;
    assign accept   = in_valid && !q_full;
    assign gol_inc  = gol_reg + 5'd1;

    always_comb
    begin
        held0_next = held0_reg;
        held1_next = held1_reg;
        cnt_byte   = cnt_reg;
        gol_next   = gol_reg;
        full_group = 1'b0;
        if (byte_present)
        begin
            if (cnt_reg < 2'd2)
            begin
                if (cnt_reg[0])
                begin
                    held1_next = data_byte;
                end
                else
                begin
                    held0_next = data_byte;
                end
                cnt_byte = cnt_reg + 2'd1;
            end
            else
            begin
                full_group = 1'b1;
                cnt_byte   = 2'd0;
                gol_next   = (gol_inc == gpl_reg) ? 5'd0 : gol_inc;
            end
        end
        tail     = end_of_message && (cnt_byte != 2'd0);
        cnt_next = cnt_byte;
        if (end_of_message)
        begin
            cnt_next = 2'd0;
            gol_next = 5'd0;
        end

        q_job.msg_last = end_of_message;
        q_job.b0       = held0_next;
        if (full_group)
        begin
            q_job.b1   = held1_next;
            q_job.b2   = data_byte;
            q_job.pad  = 2'd0;
            q_job.crlf = (gol_inc == gpl_reg);
        end
        else
        begin
            q_job.b1   = (cnt_byte == 2'd2) ? held1_next : 8'd0;
            q_job.b2   = 8'd0;
            q_job.pad  = (cnt_byte == 2'd2) ? 2'd1 : 2'd2;
            q_job.crlf = 1'b0;
        end
    end

    assign q_push = accept && (full_group || tail);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gpl_reg   <= b64enc_pkg::GROUPS_PER_LINE_RESET;
            held0_reg <= 8'd0;
            held1_reg <= 8'd0;
            cnt_reg   <= 2'd0;
            gol_reg   <= 5'd0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                gpl_reg <= cfg_wr_data;
            end
            if (accept)
            begin
                held0_reg <= held0_next;
                held1_reg <= held1_next;
                cnt_reg   <= cnt_next;
                gol_reg   <= gol_next;
            end
        end
    end

`ifndef SYNTHESIS
    a_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
        cnt_reg != 2'd3)
        else $error("held byte count out of range");
    a_end_clears: assert property (@(posedge clk) disable iff (!rst_n)
        accept && end_of_message |=> cnt_reg == 2'd0 && gol_reg == 5'd0)
        else $error("message close did not clear state");
    a_push_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("push into full queue");
`endif

endmodule

// ----- sv/b64enc_fifo.sv -----
`timescale 1ns / 1ps

module b64enc_fifo #(
    parameter int DEPTH = 2
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  b64enc_pkg::job_t push_job,
    input  logic             pop,
    output logic             full,
    output logic             empty,
    output b64enc_pkg::job_t head
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    b64enc_pkg::job_t mem_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);
    assign head  = mem_reg[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

`ifndef SYNTHESIS
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && full && !pop))
        else $error("queue overflow");
    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("queue underflow");
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(DEPTH))
        else $error("queue count out of range");
`endif

endmodule

// ----- sv/b64enc_back.sv -----
`timescale 1ns / 1ps

module b64enc_back (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             q_empty,
    input  b64enc_pkg::job_t q_head,
    output logic             q_pop,
    output logic             out_valid,
    input  logic             out_stall,
    output logic [6:0]       out_char,
    output logic             run_last,
    output logic             message_last
);

    b64enc_pkg::job_t job_reg;
    logic             active_reg;
    logic [2:0]       idx_reg;
    logic             out_valid_reg;
    logic [6:0]       char_reg, char_next;
    logic             run_last_reg;
    logic             msg_last_reg;

    logic             advance;
    logic             is_last;
    logic [23:0]      word;
    logic [2:0]       pad_start;
    logic [5:0]       sextet;

    assign advance   = active_reg && (!out_valid_reg || !out_stall);
    assign is_last   = (idx_reg == (job_reg.crlf ? b64enc_pkg::SLOT_LF : 3'd3));
    assign q_pop     = !q_empty && (!active_reg || (advance && is_last));
    assign word      = {job_reg.b0, job_reg.b1, job_reg.b2};
    assign pad_start = 3'd4 - {1'b0, job_reg.pad};

    always_comb
    begin
        case (idx_reg[1:0])
            2'd0:    sextet = word[23:18];
            2'd1:    sextet = word[17:12];
            2'd2:    sextet = word[11:6];
            default: sextet = word[5:0];
        endcase
        if (idx_reg == b64enc_pkg::SLOT_CR)
        begin
            char_next = b64enc_pkg::CH_CR;
        end
        else if (idx_reg == b64enc_pkg::SLOT_LF)
        begin
            char_next = b64enc_pkg::CH_LF;
        end
        else if (idx_reg >= pad_start)
        begin
            char_next = b64enc_pkg::CH_PAD;
        end
        else
        begin
            char_next = b64enc_pkg::sym_char(sextet);
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            job_reg <= q_head;
        end
        if (advance)
        begin
            char_reg     <= char_next;
            run_last_reg <= is_last;
            msg_last_reg <= is_last && job_reg.msg_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg    <= 1'b0;
            idx_reg       <= 3'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                active_reg <= 1'b1;
                idx_reg    <= 3'd0;
            end
            else if (advance && is_last)
            begin
                active_reg <= 1'b0;
            end
            else if (advance)
            begin
                idx_reg <= idx_reg + 3'd1;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid    = out_valid_reg;
    assign out_char     = char_reg;
    assign run_last     = run_last_reg;
    assign message_last = msg_last_reg;

`ifndef SYNTHESIS
    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> idx_reg <= b64enc_pkg::SLOT_LF)
        else $error("character slot out of range");
    a_msg_last_run_last: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && msg_last_reg |-> run_last_reg)
        else $error("message end not on last beat of its item");
    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !active_reg || (advance && is_last))
        else $error("job loaded while another is in progress");
`endif

endmodule

// ----- sv/base64_stream_encoder.sv -----
`timescale 1ns / 1ps

// Streaming Base64 encoder, standard alphabet, one message byte per input beat and one
// ASCII character per output beat. Three bytes make a group of four characters, followed
// by CR LF after every groups_per_line full groups (reset 19, i.e. 76 characters); a beat
// with end_of_message flushes a one- or two-byte tail with '=' padding and marks its last
// character with message_last. Input beats are taken one per cycle, while the queue is
// not full, into a QUEUE_DEPTH group queue; the output side spells one character per cycle
// while a job is queued and out_stall is low, so the sustained input rate is set by the
// single character output register. Write groups_per_line only while idle.
module base64_stream_encoder #(
    parameter int QUEUE_DEPTH = 2
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] data_byte,
    input  logic       byte_present,
    input  logic       end_of_message,
    input  logic       cfg_wr_en,
    input  logic [4:0] cfg_wr_data,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [6:0] out_char,
    output logic       run_last,
    output logic       message_last
);

    b64enc_pkg::job_t push_job;
    b64enc_pkg::job_t head_job;
    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_empty;

    b64enc_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .data_byte      (data_byte),
        .byte_present   (byte_present),
        .end_of_message (end_of_message),
        .cfg_wr_en      (cfg_wr_en),
        .cfg_wr_data    (cfg_wr_data),
        .q_full         (q_full),
        .q_push         (q_push),
        .q_job          (push_job)
    );

    b64enc_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .full     (q_full),
        .empty    (q_empty),
        .head     (head_job)
    );

    b64enc_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .q_empty      (q_empty),
        .q_head       (head_job),
        .q_pop        (q_pop),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .out_char     (out_char),
        .run_last     (run_last),
        .message_last (message_last)
    );

endmodule
